[sv/zwb_pkg.sv]
package zwb_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  symbol_kind;
    logic [23:0] utf8_sequence;
    logic        run_last;
  } out_item_t;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_ZERO  = 2'd1;
  localparam logic [1:0] KIND_ONE   = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam logic [23:0] SEQ_START = 24'hE281A0;
  localparam logic [23:0] SEQ_ZERO  = 24'hE2808B;
  localparam logic [23:0] SEQ_ONE   = 24'hE2808C;
  localparam logic [23:0] SEQ_END   = 24'hE281A3;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    SEL_START = 2'd0,
    SEL_BIT   = 2'd1,
    SEL_END   = 2'd2
  } sym_sel_e;

  typedef struct packed {
    logic     load;
    logic     emit;
    sym_sel_e sel;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic need_start;
    logic has_group;
    logic has_end;
    logic bit_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    priority if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

[sv/base64_zero_width_bit_encoder.sv]
// Channel  Direction  Payload     Handshake
// input    in         in_item_t   in_valid_i / in_ready_o
// output   out        out_item_t  out_valid_o / out_ready_i
//
// Input items are taken only while the sequencer is idle, so a new item waits
// until all results of the last one have entered the output register. Each
// result is registered there by the output sequencer, one symbol per cycle
// while the output register is free.
// Reset clears the group fill, start flag, sequencer and output valid.
// A stalled output holds the sequencer; the next item is taken while the last
// result still waits in the output register.
module base64_zero_width_bit_encoder
  import zwb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  zwb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  zwb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/zwb_ctrl.sv]
module zwb_ctrl
  import zwb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_GROUP = 4'b0100,
    S_END   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   grp_pend_q, grp_pend_d;
  logic   end_pend_q, end_pend_d;

  always_comb begin
    state_d    = state_q;
    grp_pend_d = grp_pend_q;
    end_pend_d = end_pend_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, emit: 1'b0, sel: SEL_START, last: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.has_result) begin
            grp_pend_d = sts_i.has_group;
            end_pend_d = sts_i.has_end;
            if (sts_i.need_start) begin
              state_d = S_START;
            end else if (sts_i.has_group) begin
              state_d = S_GROUP;
            end else begin
              state_d = S_END;
            end
          end
        end
      end
      S_START: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_START;
          cmd_o.last = !grp_pend_q && !end_pend_q;
          if (grp_pend_q) begin
            state_d = S_GROUP;
          end else if (end_pend_q) begin
            state_d = S_END;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_GROUP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_BIT;
          if (sts_i.bit_last) begin
            cmd_o.last = !end_pend_q;
            state_d    = end_pend_q ? S_END : S_IDLE;
          end
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_END;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      grp_pend_q <= 1'b0;
      end_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      grp_pend_q <= grp_pend_d;
      end_pend_q <= end_pend_d;
    end
  end

endmodule

[sv/zwb_datapath.sv]
module zwb_datapath
  import zwb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [7:0]  held0_q, held1_q;
  logic [1:0]  fill_q, fill_d;
  logic        start_sent_q, start_sent_d;
  logic [23:0] grp_q, grp_d;
  logic [2:0]  nreal_q, nreal_d;
  logic [4:0]  bit_cnt_q, bit_cnt_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic       present, msg_end, full_grp, flush;
  logic [7:0] in_byte;
  logic [1:0] char_idx;
  logic [5:0] sextet;
  logic [7:0] ch;
  logic       sym_bit;

  assign in_byte  = in_data_i.data_byte;
  assign present  = in_data_i.byte_present;
  assign msg_end  = in_data_i.message_end;
  assign full_grp = present && (fill_q == 2'd2);
  assign flush    = msg_end && !full_grp && ((fill_q != 2'd0) || present);

  assign sts_o.has_result = (present || msg_end) && (!start_sent_q || full_grp || msg_end);
  assign sts_o.need_start = !start_sent_q;
  assign sts_o.has_group  = full_grp || flush;
  assign sts_o.has_end    = msg_end;
  assign sts_o.bit_last   = (bit_cnt_q == 5'd31);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    priority if (full_grp) begin
      grp_d   = {held0_q, held1_q, in_byte};
      nreal_d = 3'd4;
    end else if (fill_q == 2'd0) begin
      grp_d   = {in_byte, 16'h0000};
      nreal_d = 3'd2;
    end else if (fill_q == 2'd1 && present) begin
      grp_d   = {held0_q, in_byte, 8'h00};
      nreal_d = 3'd3;
    end else if (fill_q == 2'd1) begin
      grp_d   = {held0_q, 16'h0000};
      nreal_d = 3'd2;
    end else begin
      grp_d   = {held0_q, held1_q, 8'h00};
      nreal_d = 3'd3;
    end
  end

  always_comb begin
    fill_d       = fill_q;
    start_sent_d = start_sent_q;
    if (cmd_i.load) begin
      if (msg_end) begin
        fill_d       = 2'd0;
        start_sent_d = 1'b0;
      end else if (present) begin
        fill_d       = full_grp ? 2'd0 : fill_q + 2'd1;
        start_sent_d = 1'b1;
      end
    end
  end

  always_comb begin
    bit_cnt_d = bit_cnt_q;
    if (cmd_i.load) begin
      bit_cnt_d = 5'd0;
    end else if (cmd_i.emit && cmd_i.sel == SEL_BIT) begin
      bit_cnt_d = bit_cnt_q + 5'd1;
    end
  end

  assign char_idx = bit_cnt_q[4:3];

  always_comb begin
    unique case (char_idx)
      2'd0:    sextet = grp_q[23:18];
      2'd1:    sextet = grp_q[17:12];
      2'd2:    sextet = grp_q[11:6];
      default: sextet = grp_q[5:0];
    endcase
  end

  assign ch      = ({1'b0, char_idx} < nreal_q) ? b64_char(sextet) : PAD_CHAR;
  assign sym_bit = ch[~bit_cnt_q[2:0]];

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d    = 1'b1;
      out_d.run_last = cmd_i.last;
      unique case (cmd_i.sel)
        SEL_START: begin
          out_d.symbol_kind   = KIND_START;
          out_d.utf8_sequence = SEQ_START;
        end
        SEL_BIT: begin
          out_d.symbol_kind   = sym_bit ? KIND_ONE : KIND_ZERO;
          out_d.utf8_sequence = sym_bit ? SEQ_ONE : SEQ_ZERO;
        end
        default: begin
          out_d.symbol_kind   = KIND_END;
          out_d.utf8_sequence = SEQ_END;
        end
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= 2'd0;
      start_sent_q <= 1'b0;
      bit_cnt_q    <= 5'd0;
      out_valid_q  <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      start_sent_q <= start_sent_d;
      bit_cnt_q    <= bit_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && present && !full_grp) begin
      if (fill_q[0]) begin
        held1_q <= in_byte;
      end else begin
        held0_q <= in_byte;
      end
    end
    if (cmd_i.load) begin
      grp_q   <= grp_d;
      nreal_q <= nreal_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/zwb_checker.sv]
module zwb_checker
  import zwb_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.message_end |=> !in_ready_o)
    else $error("ready after message end transfer");

  a_idle_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.byte_present && !in_data_i.message_end
    |=> in_ready_o)
    else $error("empty item blocked input");

  a_kind_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.symbol_kind == KIND_START && out_data_o.utf8_sequence == SEQ_START) ||
      (out_data_o.symbol_kind == KIND_ZERO && out_data_o.utf8_sequence == SEQ_ZERO) ||
      (out_data_o.symbol_kind == KIND_ONE && out_data_o.utf8_sequence == SEQ_ONE) ||
      (out_data_o.symbol_kind == KIND_END && out_data_o.utf8_sequence == SEQ_END))
    else $error("symbol kind and sequence disagree");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.symbol_kind == KIND_END |-> out_data_o.run_last)
    else $error("end marker without run_last");

endmodule

bind base64_zero_width_bit_encoder zwb_checker u_zwb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
